@@ rtl/ccsa_pkg.sv @@
package ccsa_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF     = 8;
    localparam int MAX_VOXELS_LOG2_DEF = 24;

    // Fixed field widths
    localparam int SAMPLE_W        = 8;
    localparam int PRODUCT_W       = 2 * SAMPLE_W;
    localparam int OUT_BITS        = 40;
    localparam int STAT_INDEX_BITS = 5;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 8;

    // Totals
    localparam int NUM_STATS = 20;
    localparam int NUM_CNT   = 7;
    localparam int NUM_SUM   = 10;
    localparam int NUM_PROD  = 3;
    localparam logic [STAT_INDEX_BITS-1:0] LAST_STAT_INDEX = STAT_INDEX_BITS'(NUM_STATS - 1);

    // Queue between classifier and accumulator
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH1_LOWER = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH2_LOWER = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH1_UPPER = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH2_UPPER = 2'd3;

    // Counter slots
    localparam int CNT_ALL   = 0;
    localparam int CNT_ZERO  = 1;
    localparam int CNT_NZ1   = 2;
    localparam int CNT_NZ2   = 3;
    localparam int CNT_WIN1  = 4;
    localparam int CNT_WIN2  = 5;
    localparam int CNT_COLOC = 6;

    // Intensity sum slots
    localparam int SUM_CH1         = 0;
    localparam int SUM_CH2         = 1;
    localparam int SUM_CH2_NZ1     = 2;
    localparam int SUM_CH1_NZ2     = 3;
    localparam int SUM_CH1_WIN1    = 4;
    localparam int SUM_CH2_WIN2    = 5;
    localparam int SUM_CH1_WIN2    = 6;
    localparam int SUM_CH2_WIN1    = 7;
    localparam int SUM_CH1_COLOC   = 8;
    localparam int SUM_CH2_COLOC   = 9;

    // Product sum slots
    localparam int PROD_AB = 0;
    localparam int PROD_AA = 1;
    localparam int PROD_BB = 2;

    // Input transfer payload
    typedef struct packed {
        logic [SAMPLE_W-1:0] ch1_sample;
        logic [SAMPLE_W-1:0] ch2_sample;
        logic                last_voxel;
    } voxel_t;

    // Result transfer payload
    typedef struct packed {
        logic [STAT_INDEX_BITS-1:0] stat_index;
        logic [OUT_BITS-1:0]        stat_value;
        logic                       last_stat;
    } stat_t;

    // Classified voxel, front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0]  a;
        logic [SAMPLE_W-1:0]  b;
        logic                 nz1;
        logic                 nz2;
        logic                 win1;
        logic                 win2;
        logic                 last;
        logic [PRODUCT_W-1:0] prod_ab;
        logic [PRODUCT_W-1:0] prod_aa;
        logic [PRODUCT_W-1:0] prod_bb;
    } class_t;

    // Queue head handshake toward the back end
    typedef struct packed {
        logic   valid;
        class_t item;
    } qhead_t;

endpackage

@@ rtl/colocalization_statistics_accumulator.sv @@
// Streaming two-channel colocalization totals. One voxel transfer is taken per
// clock while voxel_ready is high; a voxel goes through the classifier register
// and then the four-entry queue before the accumulator add. The
// voxel marked last is added, then all twenty totals are copied to a result
// bank and the accumulators restart from zero, so voxels keep flowing while
// the bank is read out as twenty result transfers, one per cycle that
// stat_ready is high. A second last voxel waits at the queue head until the
// bank has sent its final total; the queue and classifier absorb four voxels
// behind it before voxel_ready drops. Windows are inclusive; lower above upper
// gives an empty window. Thresholds reset to lower 0 and upper 255 and should
// be written only while the block is idle; cfg_ready is always high. Every
// total saturates at its counter width (at most 40 bits).
module colocalization_statistics_accumulator
#(
    parameter int SAMPLE_BITS     = ccsa_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_VOXELS_LOG2 = ccsa_pkg::MAX_VOXELS_LOG2_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ccsa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ccsa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 voxel_valid,
    output logic                                 voxel_ready,
    input  ccsa_pkg::voxel_t                     voxel,
    output logic                                 stat_valid,
    input  logic                                 stat_ready,
    output ccsa_pkg::stat_t                      stat
);

    logic              push_valid, push_ready, pop;
    ccsa_pkg::class_t  push_item;
    ccsa_pkg::qhead_t  head;

    assign cfg_ready = 1'b1;

    // Classifier and thresholds
    ccsa_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .voxel_valid (voxel_valid),
        .voxel_ready (voxel_ready),
        .voxel       (voxel),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    // Decoupling queue
    ccsa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .head       (head),
        .pop        (pop)
    );

    // Accumulators and result bank
    ccsa_back
    #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_VOXELS_LOG2 (MAX_VOXELS_LOG2)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .stat_valid (stat_valid),
        .stat_ready (stat_ready),
        .stat       (stat)
    );

endmodule

@@ rtl/ccsa_front.sv @@
module ccsa_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [ccsa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ccsa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 voxel_valid,
    output logic                                 voxel_ready,
    input  ccsa_pkg::voxel_t                     voxel,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output ccsa_pkg::class_t                     push_item
);

    logic [ccsa_pkg::SAMPLE_W-1:0] lo1_reg, lo2_reg, hi1_reg, hi2_reg;
    logic                          valid_reg, valid_next;
    ccsa_pkg::class_t              item_reg, item_next;
    logic                          voxel_xfer;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo1_reg <= '0;
            lo2_reg <= '0;
            hi1_reg <= '1;
            hi2_reg <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ccsa_pkg::REG_CH1_LOWER: lo1_reg <= cfg_data;
                ccsa_pkg::REG_CH2_LOWER: lo2_reg <= cfg_data;
                ccsa_pkg::REG_CH1_UPPER: hi1_reg <= cfg_data;
                ccsa_pkg::REG_CH2_UPPER: hi2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify: window compares, nonzero flags, products
    always_comb
    begin
        item_next.a       = voxel.ch1_sample;
        item_next.b       = voxel.ch2_sample;
        item_next.nz1     = (voxel.ch1_sample != '0);
        item_next.nz2     = (voxel.ch2_sample != '0);
        item_next.win1    = (voxel.ch1_sample >= lo1_reg) && (voxel.ch1_sample <= hi1_reg);
        item_next.win2    = (voxel.ch2_sample >= lo2_reg) && (voxel.ch2_sample <= hi2_reg);
        item_next.last    = voxel.last_voxel;
        item_next.prod_ab = ccsa_pkg::PRODUCT_W'(voxel.ch1_sample)
                          * ccsa_pkg::PRODUCT_W'(voxel.ch2_sample);
        item_next.prod_aa = ccsa_pkg::PRODUCT_W'(voxel.ch1_sample)
                          * ccsa_pkg::PRODUCT_W'(voxel.ch1_sample);
        item_next.prod_bb = ccsa_pkg::PRODUCT_W'(voxel.ch2_sample)
                          * ccsa_pkg::PRODUCT_W'(voxel.ch2_sample);
    end

    // Pipeline register: refills in the cycle it drains into the queue
    assign voxel_ready = !valid_reg || push_ready;
    assign voxel_xfer  = voxel_valid && voxel_ready;

    always_comb
    begin
        if (voxel_xfer)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (voxel_xfer)
            item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

@@ rtl/ccsa_queue.sv @@
module ccsa_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ccsa_pkg::class_t  push_item,
    output ccsa_pkg::qhead_t  head,
    input  logic              pop
);

    ccsa_pkg::class_t                 slot_reg [ccsa_pkg::QUEUE_DEPTH];
    logic [ccsa_pkg::QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [ccsa_pkg::QCNT_BITS-1:0]   count_reg, count_next;
    logic                             do_push, do_pop;

    assign push_ready = (count_reg != ccsa_pkg::QCNT_BITS'(ccsa_pkg::QUEUE_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/ccsa_back.sv @@
module ccsa_back
#(
    parameter int SAMPLE_BITS     = ccsa_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_VOXELS_LOG2 = ccsa_pkg::MAX_VOXELS_LOG2_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ccsa_pkg::qhead_t  head,
    output logic              pop,
    output logic              stat_valid,
    input  logic              stat_ready,
    output ccsa_pkg::stat_t   stat
);

    localparam int CNT_RAW  = MAX_VOXELS_LOG2 + 1;
    localparam int SUM_RAW  = MAX_VOXELS_LOG2 + SAMPLE_BITS;
    localparam int PROD_RAW = MAX_VOXELS_LOG2 + 2 * SAMPLE_BITS;
    localparam int CNT_W  = (CNT_RAW  > ccsa_pkg::OUT_BITS) ? ccsa_pkg::OUT_BITS : CNT_RAW;
    localparam int SUM_W  = (SUM_RAW  > ccsa_pkg::OUT_BITS) ? ccsa_pkg::OUT_BITS : SUM_RAW;
    localparam int PROD_W = (PROD_RAW > ccsa_pkg::OUT_BITS) ? ccsa_pkg::OUT_BITS : PROD_RAW;

    logic [CNT_W-1:0]  cnt_reg  [ccsa_pkg::NUM_CNT];
    logic [CNT_W-1:0]  cnt_next [ccsa_pkg::NUM_CNT];
    logic [SUM_W-1:0]  sum_reg  [ccsa_pkg::NUM_SUM];
    logic [SUM_W-1:0]  sum_next [ccsa_pkg::NUM_SUM];
    logic [PROD_W-1:0] prod_reg [ccsa_pkg::NUM_PROD];
    logic [PROD_W-1:0] prod_next[ccsa_pkg::NUM_PROD];

    logic                               cnt_inc [ccsa_pkg::NUM_CNT];
    logic [ccsa_pkg::SAMPLE_W-1:0]      sum_add [ccsa_pkg::NUM_SUM];
    logic [ccsa_pkg::PRODUCT_W-1:0]     prod_add[ccsa_pkg::NUM_PROD];

    logic [CNT_W:0]  cnt_tmp;
    logic [SUM_W:0]  sum_tmp;
    logic [PROD_W:0] prod_tmp;

    logic [ccsa_pkg::OUT_BITS-1:0]        bank_reg [ccsa_pkg::NUM_STATS];
    logic [ccsa_pkg::OUT_BITS-1:0]        bank_next[ccsa_pkg::NUM_STATS];
    logic                                 busy_reg;
    logic [ccsa_pkg::STAT_INDEX_BITS-1:0] idx_reg;
    logic                                 stat_xfer, bank_free, capture;
    ccsa_pkg::class_t                     it;

    assign it = head.item;

    // Increment selection per total
    always_comb
    begin
        cnt_inc[ccsa_pkg::CNT_ALL]   = 1'b1;
        cnt_inc[ccsa_pkg::CNT_ZERO]  = !it.nz1 && !it.nz2;
        cnt_inc[ccsa_pkg::CNT_NZ1]   = it.nz1;
        cnt_inc[ccsa_pkg::CNT_NZ2]   = it.nz2;
        cnt_inc[ccsa_pkg::CNT_WIN1]  = it.win1;
        cnt_inc[ccsa_pkg::CNT_WIN2]  = it.win2;
        cnt_inc[ccsa_pkg::CNT_COLOC] = it.win1 && it.win2;

        sum_add[ccsa_pkg::SUM_CH1]       = it.a;
        sum_add[ccsa_pkg::SUM_CH2]       = it.b;
        sum_add[ccsa_pkg::SUM_CH2_NZ1]   = it.nz1 ? it.b : '0;
        sum_add[ccsa_pkg::SUM_CH1_NZ2]   = it.nz2 ? it.a : '0;
        sum_add[ccsa_pkg::SUM_CH1_WIN1]  = it.win1 ? it.a : '0;
        sum_add[ccsa_pkg::SUM_CH2_WIN2]  = it.win2 ? it.b : '0;
        sum_add[ccsa_pkg::SUM_CH1_WIN2]  = it.win2 ? it.a : '0;
        sum_add[ccsa_pkg::SUM_CH2_WIN1]  = it.win1 ? it.b : '0;
        sum_add[ccsa_pkg::SUM_CH1_COLOC] = (it.win1 && it.win2) ? it.a : '0;
        sum_add[ccsa_pkg::SUM_CH2_COLOC] = (it.win1 && it.win2) ? it.b : '0;

        prod_add[ccsa_pkg::PROD_AB] = (it.win1 && it.win2) ? it.prod_ab : '0;
        prod_add[ccsa_pkg::PROD_AA] = (it.win1 && it.win2) ? it.prod_aa : '0;
        prod_add[ccsa_pkg::PROD_BB] = (it.win1 && it.win2) ? it.prod_bb : '0;
    end

    // Saturating adds: carry out means the total hit its cap
    always_comb
    begin
        for (int i = 0; i < ccsa_pkg::NUM_CNT; i++)
        begin
            cnt_tmp     = {1'b0, cnt_reg[i]} + (CNT_W+1)'(cnt_inc[i]);
            cnt_next[i] = cnt_tmp[CNT_W] ? '1 : cnt_tmp[CNT_W-1:0];
        end
        for (int i = 0; i < ccsa_pkg::NUM_SUM; i++)
        begin
            sum_tmp     = {1'b0, sum_reg[i]} + (SUM_W+1)'(sum_add[i]);
            sum_next[i] = sum_tmp[SUM_W] ? '1 : sum_tmp[SUM_W-1:0];
        end
        for (int i = 0; i < ccsa_pkg::NUM_PROD; i++)
        begin
            prod_tmp     = {1'b0, prod_reg[i]} + (PROD_W+1)'(prod_add[i]);
            prod_next[i] = prod_tmp[PROD_W] ? '1 : prod_tmp[PROD_W-1:0];
        end
    end

    // Output order of the totals
    always_comb
    begin
        bank_next[0]  = ccsa_pkg::OUT_BITS'(cnt_next[ccsa_pkg::CNT_ALL]);
        bank_next[1]  = ccsa_pkg::OUT_BITS'(cnt_next[ccsa_pkg::CNT_ZERO]);
        bank_next[2]  = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH1]);
        bank_next[3]  = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH2]);
        bank_next[4]  = ccsa_pkg::OUT_BITS'(cnt_next[ccsa_pkg::CNT_NZ1]);
        bank_next[5]  = ccsa_pkg::OUT_BITS'(cnt_next[ccsa_pkg::CNT_NZ2]);
        bank_next[6]  = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH2_NZ1]);
        bank_next[7]  = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH1_NZ2]);
        bank_next[8]  = ccsa_pkg::OUT_BITS'(cnt_next[ccsa_pkg::CNT_WIN1]);
        bank_next[9]  = ccsa_pkg::OUT_BITS'(cnt_next[ccsa_pkg::CNT_WIN2]);
        bank_next[10] = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH1_WIN1]);
        bank_next[11] = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH2_WIN2]);
        bank_next[12] = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH1_WIN2]);
        bank_next[13] = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH2_WIN1]);
        bank_next[14] = ccsa_pkg::OUT_BITS'(cnt_next[ccsa_pkg::CNT_COLOC]);
        bank_next[15] = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH1_COLOC]);
        bank_next[16] = ccsa_pkg::OUT_BITS'(sum_next[ccsa_pkg::SUM_CH2_COLOC]);
        bank_next[17] = ccsa_pkg::OUT_BITS'(prod_next[ccsa_pkg::PROD_AB]);
        bank_next[18] = ccsa_pkg::OUT_BITS'(prod_next[ccsa_pkg::PROD_AA]);
        bank_next[19] = ccsa_pkg::OUT_BITS'(prod_next[ccsa_pkg::PROD_BB]);
    end

    // Pop control: a last voxel waits until the result bank is free
    assign stat_xfer = stat_valid && stat_ready;
    assign bank_free = !busy_reg || (stat_xfer && (idx_reg == ccsa_pkg::LAST_STAT_INDEX));
    assign pop       = head.valid && (!it.last || bank_free);
    assign capture   = pop && it.last;

    // Accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ccsa_pkg::NUM_CNT; i++)
                cnt_reg[i] <= '0;
            for (int i = 0; i < ccsa_pkg::NUM_SUM; i++)
                sum_reg[i] <= '0;
            for (int i = 0; i < ccsa_pkg::NUM_PROD; i++)
                prod_reg[i] <= '0;
        end
        else if (pop)
        begin
            for (int i = 0; i < ccsa_pkg::NUM_CNT; i++)
                cnt_reg[i] <= capture ? '0 : cnt_next[i];
            for (int i = 0; i < ccsa_pkg::NUM_SUM; i++)
                sum_reg[i] <= capture ? '0 : sum_next[i];
            for (int i = 0; i < ccsa_pkg::NUM_PROD; i++)
                prod_reg[i] <= capture ? '0 : prod_next[i];
        end
    end

    // Result bank
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int i = 0; i < ccsa_pkg::NUM_STATS; i++)
                bank_reg[i] <= bank_next[i];
        end
    end

    // Emission sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (capture)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (stat_xfer)
        begin
            if (idx_reg == ccsa_pkg::LAST_STAT_INDEX)
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign stat_valid      = busy_reg;
    assign stat.stat_index = idx_reg;
    assign stat.stat_value = bank_reg[idx_reg];
    assign stat.last_stat  = (idx_reg == ccsa_pkg::LAST_STAT_INDEX);

endmodule

@@ rtl/ccsa_checker.sv @@
module ccsa_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             stat_valid,
    input logic             stat_ready,
    input ccsa_pkg::stat_t  stat
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid && !stat_ready |=> stat_valid && $stable(stat))
        else $error("stalled result changed");

    // Final flag marks exactly the last total
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid |-> (stat.last_stat == (stat.stat_index == ccsa_pkg::LAST_STAT_INDEX)))
        else $error("last_stat does not match stat_index");

    // Totals follow one another without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid && stat_ready && !stat.last_stat |=>
            stat_valid && (stat.stat_index == $past(stat.stat_index) + 1'b1))
        else $error("total sequence broken");

    // Index stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid |-> stat.stat_index <= ccsa_pkg::LAST_STAT_INDEX)
        else $error("stat_index out of range");

endmodule

bind colocalization_statistics_accumulator ccsa_checker u_ccsa_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .stat_valid (stat_valid),
    .stat_ready (stat_ready),
    .stat       (stat)
);
